FILE: src/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants for the infix expression evaluator
// Character codes, operator kinds and sequencer states.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam int unsigned OUT_W = 32;

  typedef enum logic [1:0] {
    MOP_NONE = 2'd0,
    MOP_MUL  = 2'd1,
    MOP_DIV  = 2'd2
  } mul_op_t;

  typedef enum logic [2:0] {
    OPK_ADD = 3'd0,
    OPK_SUB = 3'd1,
    OPK_MUL = 3'd2,
    OPK_DIV = 3'd3,
    OPK_EQ  = 3'd4
  } op_kind_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_DNA  = 3'd2,
    S_DNB  = 3'd3,
    S_DIV  = 3'd4,
    S_DNQ  = 3'd5,
    S_POST = 3'd6,
    S_SUM  = 3'd7
  } state_t;

endpackage

FILE: src/iee_in_if.sv
// ----------------------------------------------------------------------------
// iee_in_if: character input channel
// Valid/ready channel carrying one ASCII character per transfer.
// ----------------------------------------------------------------------------
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

FILE: src/iee_out_if.sv
// ----------------------------------------------------------------------------
// iee_out_if: result output channel
// Valid/ready channel carrying the expression value and the divide-by-zero flag.
// ----------------------------------------------------------------------------
interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               div_by_zero;

  modport source (output valid, output value, output div_by_zero, input ready);
  modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

FILE: src/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator: two-precedence infix arithmetic evaluator
// Reads one ASCII character per transfer; '=' emits the signed result.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                     | transfer
//  ---------+-----+-----------------------------+-----------------------
//  in_ch    | in  | char_code[7:0]              | valid && ready
//  out_ch   | out | value[31:0] s, div_by_zero  | valid && ready
//
//  Digits and ignored characters are taken in S_IDLE. An operator with no
//  pending '*' or '/' passes S_POST ('+', '-', '=' then add the S_SUM step).
//  A pending multiply adds the S_MUL shift-add loop, a pending divide the
//  S_DNA/S_DNB sign fix-up, the S_DIV loop (one quotient bit per cycle) and
//  S_DNQ, all through the one shared add/subtract unit. '=' then loads the
//  output register, and waits there while a previous result is not taken.
//  Reset (rst_n low, synchronous) clears the expression state and the output.
// ----------------------------------------------------------------------------
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);

  localparam int unsigned W     = WORD_WIDTH;
  localparam int unsigned CNT_W = $clog2(WORD_WIDTH);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_WIDTH - 1);

  // expression state
  state_t         state_r, state_nxt;
  logic [W-1:0]   num_r, num_nxt;
  logic [W-1:0]   term_r, term_nxt;
  logic [W-1:0]   sum_r, sum_nxt;
  mul_op_t        pend_mul_r, pend_mul_nxt;
  logic           pend_sub_r, pend_sub_nxt;
  logic           err_r, err_nxt;

  // working registers of the shared unit
  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   sh_r, sh_nxt;
  logic [W-1:0]   opd_r, opd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           neg_q_r, neg_q_nxt;
  op_kind_t       op_r, op_nxt;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_dz_r;
  logic               out_load;
  logic               done_pend_r, done_pend_nxt;

  // shared add/subtract unit
  logic [W+1:0] alu_a, alu_b, alu_res;
  logic         alu_sub;
  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  logic [3:0] dig;
  logic       is_digit, is_op;
  op_kind_t   in_kind;

  assign dig      = 4'(in_ch.char_code - CH_0);
  assign is_digit = (in_ch.char_code >= CH_0) && (in_ch.char_code <= CH_9);

  always_comb begin
    is_op   = 1'b1;
    in_kind = OPK_ADD;
    unique case (in_ch.char_code)
      CH_PLUS:  in_kind = OPK_ADD;
      CH_MINUS: in_kind = OPK_SUB;
      CH_STAR:  in_kind = OPK_MUL;
      CH_SLASH: in_kind = OPK_DIV;
      CH_EQ:    in_kind = OPK_EQ;
      default:  is_op = 1'b0;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE) && !done_pend_r;

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    pend_mul_nxt  = pend_mul_r;
    pend_sub_nxt  = pend_sub_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    opd_nxt       = opd_r;
    cnt_nxt       = cnt_r;
    neg_q_nxt     = neg_q_r;
    op_nxt        = op_r;
    done_pend_nxt = done_pend_r;
    out_load      = 1'b0;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (done_pend_r) begin
          // wait for the output register, then start a fresh expression
          if (!out_valid_r || out_ch.ready) begin
            out_load      = 1'b1;
            done_pend_nxt = 1'b0;
            num_nxt       = '0;
            term_nxt      = '0;
            sum_nxt       = '0;
            pend_mul_nxt  = MOP_NONE;
            pend_sub_nxt  = 1'b0;
            err_nxt       = 1'b0;
          end
        end else if (in_ch.valid) begin
          if (is_digit) begin
            num_nxt = (num_r << 3) + (num_r << 1) + W'(dig);
          end else if (is_op) begin
            op_nxt  = in_kind;
            num_nxt = '0;
            unique case (pend_mul_r)
              MOP_MUL: begin
                acc_nxt   = '0;
                sh_nxt    = term_r;
                opd_nxt   = num_r;
                cnt_nxt   = CNT_MAX;
                state_nxt = S_MUL;
              end
              MOP_DIV: begin
                if (num_r == '0) begin
                  term_nxt  = '0;
                  err_nxt   = 1'b1;
                  state_nxt = S_POST;
                end else begin
                  opd_nxt   = num_r;
                  state_nxt = S_DNA;
                end
              end
              default: begin
                term_nxt  = num_r;
                state_nxt = S_POST;
              end
            endcase
          end
        end
      end

      S_MUL: begin
        alu_a   = {2'b00, acc_r};
        alu_b   = opd_r[0] ? {2'b00, sh_r} : '0;
        acc_nxt = alu_res[W-1:0];
        sh_nxt  = sh_r << 1;
        opd_nxt = opd_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          term_nxt  = alu_res[W-1:0];
          state_nxt = S_POST;
        end
      end

      S_DNA: begin
        // magnitude of the dividend
        alu_b     = {2'b00, term_r};
        alu_sub   = 1'b1;
        neg_q_nxt = term_r[W-1] ^ opd_r[W-1];
        sh_nxt    = term_r[W-1] ? alu_res[W-1:0] : term_r;
        state_nxt = S_DNB;
      end

      S_DNB: begin
        // magnitude of the divisor
        alu_b     = {2'b00, opd_r};
        alu_sub   = 1'b1;
        opd_nxt   = opd_r[W-1] ? alu_res[W-1:0] : opd_r;
        acc_nxt   = '0;
        cnt_nxt   = CNT_MAX;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        // restoring step: shift in the next dividend bit, try to subtract
        alu_a   = {1'b0, acc_r, sh_r[W-1]};
        alu_b   = {2'b00, opd_r};
        alu_sub = 1'b1;
        if (!alu_res[W+1]) begin
          acc_nxt = alu_res[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[W-2:0], sh_r[W-1]};
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DNQ;
        end
      end

      S_DNQ: begin
        alu_b     = {2'b00, sh_r};
        alu_sub   = 1'b1;
        term_nxt  = neg_q_r ? alu_res[W-1:0] : sh_r;
        state_nxt = S_POST;
      end

      S_POST: begin
        if (op_r == OPK_MUL) begin
          pend_mul_nxt = MOP_MUL;
          state_nxt    = S_IDLE;
        end else if (op_r == OPK_DIV) begin
          pend_mul_nxt = MOP_DIV;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        alu_a         = {2'b00, sum_r};
        alu_b         = {2'b00, term_r};
        alu_sub       = pend_sub_r;
        sum_nxt       = alu_res[W-1:0];
        term_nxt      = '0;
        pend_mul_nxt  = MOP_NONE;
        pend_sub_nxt  = (op_r == OPK_SUB);
        done_pend_nxt = (op_r == OPK_EQ);
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_r       <= '0;
      term_r      <= '0;
      sum_r       <= '0;
      pend_mul_r  <= MOP_NONE;
      pend_sub_r  <= 1'b0;
      err_r       <= 1'b0;
      done_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_r       <= num_nxt;
      term_r      <= term_nxt;
      sum_r       <= sum_nxt;
      pend_mul_r  <= pend_mul_nxt;
      pend_sub_r  <= pend_sub_nxt;
      err_r       <= err_nxt;
      done_pend_r <= done_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    sh_r    <= sh_nxt;
    opd_r   <= opd_nxt;
    cnt_r   <= cnt_nxt;
    neg_q_r <= neg_q_nxt;
    op_r    <= op_nxt;
  end

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= err_r ? '0 : OUT_W'($signed(sum_r));
      out_dz_r    <= err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.div_by_zero = out_dz_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.div_by_zero |-> out_ch.value == '0)
    else $error("divide-by-zero result carries a nonzero value");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> acc_r < opd_r)
    else $error("partial remainder not below divisor");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_MUL) && cnt_r != '0 |=>
      cnt_r == CNT_W'($past(cnt_r) - 1'b1))
    else $error("iteration counter skipped a step");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> sum_r == '0 && term_r == '0 && num_r == '0 &&
                 pend_mul_r == MOP_NONE && !err_r && out_valid_r)
    else $error("state not cleared after result load");

endmodule
